/* rtl/npad_pkg.sv */
// ----------------------------------------------------------------------------
// npad_pkg
// Shared widths, codes and controller/datapath bundles for the
// nearest-point actuator dispatch block.
// ----------------------------------------------------------------------------
`default_nettype none

package npad_pkg;

    localparam int ENTRIES_DEF    = 32;
    localparam int COORD_BITS_DEF = 8;
    localparam int LEVEL_BITS_DEF = 16;

    localparam int SLOT_W  = 5;
    localparam int POS_W   = 8;
    localparam int LVL_W   = 16;
    localparam int DIST_W  = 17;

    localparam logic [DIST_W-1:0] DIST_MAX = 17'h1FFFF;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_EFFECT = 1'b1;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_EFFECT = 1'b1;

    typedef struct packed {
        logic load;       // write table slot from the accepted item
        logic start;      // latch target, clear tracker, rewind address
        logic step;       // read one slot this cycle
        logic out_load;   // load the result register
        logic out_effect; // result register takes the effect outcome
    } t_cmd;

    typedef struct packed {
        logic addr_last;
        logic pipe_empty;
    } t_sts;

endpackage

`default_nettype wire

/* rtl/npad_ifs.sv */
// ----------------------------------------------------------------------------
// npad item and result channels
// Valid/ready channels carrying the input item and the result item.
// ----------------------------------------------------------------------------
`default_nettype none

interface npad_item_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [npad_pkg::SLOT_W-1:0] slot;
    logic                        slot_enable;
    logic [npad_pkg::POS_W-1:0]  pos_x;
    logic [npad_pkg::POS_W-1:0]  pos_y;
    logic [npad_pkg::LVL_W-1:0]  level;

    modport source (output valid, opcode, slot, slot_enable, pos_x, pos_y, level,
                    input ready);
    modport sink   (input valid, opcode, slot, slot_enable, pos_x, pos_y, level,
                    output ready);
endinterface

interface npad_result_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic                        served;
    logic                        exact_hit;
    logic [npad_pkg::SLOT_W-1:0] chosen_slot;
    logic [npad_pkg::LVL_W-1:0]  drive_level;
    logic [npad_pkg::DIST_W-1:0] distance_sq;

    modport source (output valid, kind, served, exact_hit, chosen_slot, drive_level,
                    distance_sq, input ready);
    modport sink   (input valid, kind, served, exact_hit, chosen_slot, drive_level,
                    distance_sq, output ready);
endinterface

`default_nettype wire

/* rtl/npad_ctrl.sv */
// ----------------------------------------------------------------------------
// npad_ctrl
// Sequencer: accepts an item, runs the table scan for effects, and hands
// the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module npad_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic          i_in_op,
    output logic               o_in_ready,
    input  wire logic          i_out_ready,
    output logic               o_out_valid,
    output npad_pkg::t_cmd     o_cmd,
    input  wire npad_pkg::t_sts i_sts
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_LRES,
        S_ERES
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in_op == npad_pkg::OP_LOAD) begin
                        o_cmd.load = 1'b1;
                        n_state    = S_LRES;
                    end else begin
                        o_cmd.start = 1'b1;
                        n_state     = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_sts.addr_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (i_sts.pipe_empty) begin
                    n_state = S_ERES;
                end
            end
            S_LRES, S_ERES: begin
                if (out_free) begin
                    o_cmd.out_load   = 1'b1;
                    o_cmd.out_effect = (r_state == S_ERES);
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

/* rtl/npad_dp.sv */
// ----------------------------------------------------------------------------
// npad_dp
// Datapath: position tables, valid bits, level store, scan pipeline with
// nearest-point tracker, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module npad_dp #(
    parameter int ENTRIES    = npad_pkg::ENTRIES_DEF,
    parameter int COORD_BITS = npad_pkg::COORD_BITS_DEF,
    parameter int LEVEL_BITS = npad_pkg::LEVEL_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire npad_pkg::t_cmd               i_cmd,
    output npad_pkg::t_sts                    o_sts,
    input  wire logic                         i_cfg_we,
    input  wire logic                         i_cfg_data,
    input  wire logic [npad_pkg::SLOT_W-1:0]  i_slot,
    input  wire logic                         i_slot_enable,
    input  wire logic [npad_pkg::POS_W-1:0]   i_pos_x,
    input  wire logic [npad_pkg::POS_W-1:0]   i_pos_y,
    input  wire logic [npad_pkg::LVL_W-1:0]   i_level,
    output logic                              o_kind,
    output logic                              o_served,
    output logic                              o_exact_hit,
    output logic [npad_pkg::SLOT_W-1:0]       o_chosen_slot,
    output logic [npad_pkg::LVL_W-1:0]        o_drive_level,
    output logic [npad_pkg::DIST_W-1:0]       o_distance_sq
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SQ_W  = 2 * COORD_BITS;
    localparam int DW    = SQ_W + 1;
    localparam int KEY_W = DW + 2 * COORD_BITS;
    localparam int EXT_W = DW + npad_pkg::DIST_W;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

    // storage
    logic [COORD_BITS-1:0] r_xmem [ENTRIES];
    logic [COORD_BITS-1:0] r_ymem [ENTRIES];
    logic [LEVEL_BITS-1:0] r_lvlmem [ENTRIES];
    logic [ENTRIES-1:0]    r_valid;
    logic                  r_closest;

    // item latches
    logic [COORD_BITS-1:0] r_tx, r_ty;
    logic [LEVEL_BITS-1:0] r_lvl;
    logic [IDX_W-1:0]      r_addr;
    logic [npad_pkg::SLOT_W-1:0] r_ld_slot;

    // scan pipeline
    logic                  r_a_vld, r_a_en;
    logic [IDX_W-1:0]      r_a_idx;
    logic [COORD_BITS-1:0] r_a_x, r_a_y;
    logic                  r_b_vld, r_b_en;
    logic [IDX_W-1:0]      r_b_idx;
    logic [COORD_BITS-1:0] r_b_x, r_b_y;
    logic [SQ_W-1:0]       r_b_sqx, r_b_sqy;

    // tracker
    logic                  r_found;
    logic [KEY_W-1:0]      r_best_key;
    logic [IDX_W-1:0]      r_best_idx;

    logic [COORD_BITS-1:0] in_x, in_y, dx, dy;
    logic [DW-1:0]         cand_d, best_d;
    logic [KEY_W-1:0]      cand_key;
    logic                  in_range;
    logic [IDX_W-1:0]      ld_idx;
    logic                  served, exact;
    logic [EXT_W-1:0]      d_ext;
    logic [npad_pkg::DIST_W-1:0] d_sat;

    assign in_x     = COORD_BITS'(i_pos_x);
    assign in_y     = COORD_BITS'(i_pos_y);
    assign in_range = (32'(i_slot) < 32'(ENTRIES));
    assign ld_idx   = IDX_W'(i_slot);

    assign o_sts.addr_last  = (r_addr == IDX_LAST);
    assign o_sts.pipe_empty = !r_a_vld && !r_b_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_closest <= 1'b1;
        end else if (i_cfg_we) begin
            r_closest <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.load && in_range) begin
            r_valid[ld_idx] <= i_slot_enable;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && in_range) begin
            r_xmem[ld_idx] <= in_x;
            r_ymem[ld_idx] <= in_y;
        end
        if (i_cmd.step) begin
            r_a_x <= r_xmem[r_addr];
            r_a_y <= r_ymem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && in_range) begin
            r_lvlmem[ld_idx] <= '0;
        end else if (i_cmd.out_load && i_cmd.out_effect && served) begin
            r_lvlmem[r_best_idx] <= r_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ld_slot <= i_slot;
        end
        if (i_cmd.start) begin
            r_tx   <= in_x;
            r_ty   <= in_y;
            r_lvl  <= LEVEL_BITS'(i_level);
            r_addr <= '0;
        end else if (i_cmd.step) begin
            r_addr <= r_addr + IDX_W'(1);
        end
        if (i_cmd.step) begin
            r_a_idx <= r_addr;
            r_a_en  <= r_valid[r_addr];
        end
    end

    // stage B: absolute differences and squares
    assign dx = (r_a_x > r_tx) ? (r_a_x - r_tx) : (r_tx - r_a_x);
    assign dy = (r_a_y > r_ty) ? (r_a_y - r_ty) : (r_ty - r_a_y);

    always_ff @(posedge i_clk) begin
        r_b_sqx <= SQ_W'(dx) * SQ_W'(dx);
        r_b_sqy <= SQ_W'(dy) * SQ_W'(dy);
        r_b_x   <= r_a_x;
        r_b_y   <= r_a_y;
        r_b_idx <= r_a_idx;
        r_b_en  <= r_a_en;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
        end else begin
            r_a_vld <= i_cmd.step;
            r_b_vld <= r_a_vld;
        end
    end

    // tracker: key orders by distance, then x, then y; ties keep the earlier slot
    assign cand_d   = DW'(r_b_sqx) + DW'(r_b_sqy);
    assign cand_key = {cand_d, r_b_x, r_b_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.start) begin
            r_found <= 1'b0;
        end else if (r_b_vld && r_b_en && (!r_found || cand_key < r_best_key)) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_vld && r_b_en && (!r_found || cand_key < r_best_key)) begin
            r_best_key <= cand_key;
            r_best_idx <= r_b_idx;
        end
    end

    assign best_d = r_best_key[KEY_W-1 -: DW];
    assign exact  = r_found && (best_d == '0);
    assign served = r_found && (r_closest || exact);
    assign d_ext  = EXT_W'(best_d);
    assign d_sat  = (d_ext > EXT_W'(npad_pkg::DIST_MAX)) ? npad_pkg::DIST_MAX
                                                         : npad_pkg::DIST_W'(d_ext);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (i_cmd.out_effect) begin
                o_kind        <= npad_pkg::KIND_EFFECT;
                o_served      <= served;
                o_exact_hit   <= served && exact;
                o_chosen_slot <= served ? npad_pkg::SLOT_W'(r_best_idx) : '0;
                o_drive_level <= served ? npad_pkg::LVL_W'(r_lvl) : '0;
                o_distance_sq <= (served && !exact) ? d_sat : '0;
            end else begin
                o_kind        <= npad_pkg::KIND_LOAD;
                o_served      <= 1'b0;
                o_exact_hit   <= 1'b0;
                o_chosen_slot <= r_ld_slot;
                o_drive_level <= '0;
                o_distance_sq <= '0;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/nearest_point_actuator_dispatch.sv */
// ----------------------------------------------------------------------------
// nearest_point_actuator_dispatch
// Actuator position table with exact-match or nearest-point effect dispatch.
// ----------------------------------------------------------------------------
// One item is processed at a time. A load item writes its slot when it is
// accepted and then reaches the result register once that register is free;
// an effect item scans every table slot through the position memory's single
// read port, one slot per cycle, waits for the scan pipeline to drain, and
// then loads its result once the result register is free. That register
// holds each result until it is taken, and the next item is accepted as soon
// as the previous result has been loaded there.
// Slots come up empty after reset; no clearing pass is needed.
`default_nettype none

module nearest_point_actuator_dispatch #(
    parameter int ENTRIES    = npad_pkg::ENTRIES_DEF,
    parameter int COORD_BITS = npad_pkg::COORD_BITS_DEF,
    parameter int LEVEL_BITS = npad_pkg::LEVEL_BITS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cfg_we,
    input  wire logic     i_cfg_data,
    npad_item_if.sink     i_item,
    npad_result_if.source o_result
);

    npad_pkg::t_cmd cmd;
    npad_pkg::t_sts sts;

    npad_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .i_in_op     (i_item.opcode),
        .o_in_ready  (i_item.ready),
        .i_out_ready (o_result.ready),
        .o_out_valid (o_result.valid),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    npad_dp #(
        .ENTRIES    (ENTRIES),
        .COORD_BITS (COORD_BITS),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_slot        (i_item.slot),
        .i_slot_enable (i_item.slot_enable),
        .i_pos_x       (i_item.pos_x),
        .i_pos_y       (i_item.pos_y),
        .i_level       (i_item.level),
        .o_kind        (o_result.kind),
        .o_served      (o_result.served),
        .o_exact_hit   (o_result.exact_hit),
        .o_chosen_slot (o_result.chosen_slot),
        .o_drive_level (o_result.drive_level),
        .o_distance_sq (o_result.distance_sq)
    );

endmodule

`default_nettype wire
